// ===== src/threshold_boundary_edge_3x3_top_macros.svh =====
// assertion macros for the threshold boundary edge block
// expects signals named clock and reset in the scope of each use
`ifndef THRESHOLD_BOUNDARY_EDGE_3X3_TOP_MACROS_SVH
`define THRESHOLD_BOUNDARY_EDGE_3X3_TOP_MACROS_SVH

// same-cycle implication
`define TBE_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TBE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/tbe_pkg.sv =====
// shared types and constants of the threshold boundary edge block
// no dependencies
`default_nettype none

package tbe_pkg;

   localparam int CHAN_W    = 8;
   localparam int NUM_CHAN  = 3;
   localparam int PIX_W     = CHAN_W * NUM_CHAN;
   localparam int SIZE_W    = 9;
   localparam int ROW_W     = 8;
   localparam int SIZE_MIN  = 3;
   localparam int ROWS_MAX  = 256;
   localparam int WIN_SIZE  = 9;
   localparam int WIN_CENTRE = 4;
   localparam int CSR_IDX_W = 2;

   localparam logic [CHAN_W-1:0] THRESH_RESET = 8'd110;
   localparam logic [CHAN_W-1:0] BRIGHT       = 8'hFF;
   localparam logic [CHAN_W-1:0] DARK         = 8'h00;

   typedef logic [PIX_W-1:0] pixel_type;
   typedef logic [WIN_SIZE-1:0][PIX_W-1:0] window_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THRESHOLD = 2'd0,
      CSR_COLUMNS   = 2'd1,
      CSR_ROWS      = 2'd2
   } csr_index_type;

endpackage

`default_nettype wire

// ===== src/tbe_ifs.sv =====
// channel interfaces: pixel requests, edge results, register writes
// depends on tbe_pkg
`default_nettype none

interface tbe_req_if;
   logic                      valid;
   logic                      ready;
   logic                      mode;
   logic [tbe_pkg::CHAN_W-1:0] red_in;
   logic [tbe_pkg::CHAN_W-1:0] green_in;
   logic [tbe_pkg::CHAN_W-1:0] blue_in;

   modport source (output valid, mode, red_in, green_in, blue_in, input ready);
   modport sink   (input valid, mode, red_in, green_in, blue_in, output ready);
endinterface

interface tbe_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [tbe_pkg::CHAN_W-1:0] red_out;
   logic [tbe_pkg::CHAN_W-1:0] green_out;
   logic [tbe_pkg::CHAN_W-1:0] blue_out;
   logic                      frame_end;

   modport source (output valid, red_out, green_out, blue_out, frame_end, input ready);
   modport sink   (input valid, red_out, green_out, blue_out, frame_end, output ready);
endinterface

interface tbe_csr_if;
   logic                         valid;
   logic                         ready;
   logic [tbe_pkg::CSR_IDX_W-1:0] index;
   logic [tbe_pkg::SIZE_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/tbe_ram.sv =====
// generic simple dual port ram, one write and one registered read port
// no dependencies
`default_nettype none

module tbe_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== src/tbe_judge.sv =====
// per-channel edge decision for the center of a 3x3 window
// depends on tbe_pkg
`default_nettype none

module tbe_judge (
   input  wire tbe_pkg::window_type                window,
   input  wire logic [tbe_pkg::CHAN_W-1:0]         threshold,
   output      logic [tbe_pkg::NUM_CHAN-1:0]       dark
);

   logic [tbe_pkg::NUM_CHAN-1:0] low_centre;
   logic [tbe_pkg::NUM_CHAN-1:0] hot_any;

   always_comb begin
      low_centre = '0;
      hot_any    = '0;
      for (int k = 0; k < tbe_pkg::NUM_CHAN; k++) begin
         low_centre[k] = window[tbe_pkg::WIN_CENTRE][k*tbe_pkg::CHAN_W +: tbe_pkg::CHAN_W]
                         < threshold;
         for (int n = 0; n < tbe_pkg::WIN_SIZE; n++) begin
            if (n != tbe_pkg::WIN_CENTRE &&
                window[n][k*tbe_pkg::CHAN_W +: tbe_pkg::CHAN_W] > threshold) begin
               hot_any[k] = 1'b1;
            end
         end
      end
   end

   // dark only when the center is below and some neighbor is above
   assign dark = low_centre & hot_any;

endmodule

`default_nettype wire

// ===== src/threshold_boundary_edge_3x3_top.sv =====
// top level of the 3x3 threshold boundary edge detector
// depends on tbe_pkg, tbe_ifs, tbe_ram, tbe_judge and the assertion macro header
//
//   channel  | dir | fields                                    | beat
//   req_bus  | in  | mode, red_in, green_in, blue_in           | pixel or flush tick
//   rsp_bus  | out | red_out, green_out, blue_out, frame_end   | one edge result
//   csr_bus  | in  | index, data                               | register write
//
// one beat per clock while rsp_bus does not stall; the beat that completes a window is registered
// in the compare stage, then its result in the output register (line store read, then window and compare)
// the single line store ram port pair sets the pace: one read and one write per clock
// synchronous reset clears counters, window and valid flags; line stores are not cleared
// a stalled result holds the compare stage, which in turn holds req_bus.ready low
`default_nettype none
`include "threshold_boundary_edge_3x3_top_macros.svh"

module threshold_boundary_edge_3x3_top #(
   parameter int MAX_LINE_WIDTH = 256
) (
   input wire logic   clock,
   input wire logic   reset,
   tbe_req_if.sink    req_bus,
   tbe_rsp_if.source  rsp_bus,
   tbe_csr_if.sink    csr_bus
);

   localparam int COL_W  = $clog2(MAX_LINE_WIDTH);
   localparam int CNT_W  = $clog2(MAX_LINE_WIDTH + 1);
   localparam int PEND_W = $clog2(MAX_LINE_WIDTH + 2);
   localparam int SAT_W  = (CNT_W > tbe_pkg::SIZE_W) ? CNT_W : tbe_pkg::SIZE_W;
   localparam int COLS_RESET = (MAX_LINE_WIDTH < 256) ? MAX_LINE_WIDTH : 256;

   typedef struct packed {
      logic                pixel;
      logic                emit;
      logic                bright;
      logic                last;
      tbe_pkg::pixel_type  px;
      logic [COL_W-1:0]    col;
   } stage_type;

   // configuration
   logic [tbe_pkg::CHAN_W-1:0] threshold_ff, threshold_in;
   logic [CNT_W-1:0]           cols_ff, cols_in;
   logic [tbe_pkg::SIZE_W-1:0] rows_ff, rows_in;
   logic                       restart;
   logic [SAT_W-1:0]           raw_cols;
   logic [tbe_pkg::SIZE_W-1:0] raw_rows;

   // position tracking
   logic [COL_W-1:0]           in_col_ff, in_col_in;
   logic [COL_W-1:0]           out_col_ff, out_col_in;
   logic [tbe_pkg::ROW_W-1:0]  out_row_ff, out_row_in;
   logic [PEND_W-1:0]          pend_ff, pend_in;

   // datapath
   logic                       req_fire, is_pixel, emit_c, bright_c, last_c;
   logic                       col_first, col_last, row_first, row_last, in_col_last;
   logic [PEND_W-1:0]          cols_p1;
   logic                       s1_valid_ff, s1_valid_in, s1_fire;
   stage_type                  s1_ff, s1_in;
   tbe_pkg::window_type        win_ff, win_next;
   logic [2*tbe_pkg::PIX_W-1:0] ram_rdata, ram_wdata;
   logic                       ram_we, ram_re;
   logic [tbe_pkg::NUM_CHAN-1:0] dark;
   logic                       out_free;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [tbe_pkg::NUM_CHAN-1:0][tbe_pkg::CHAN_W-1:0] rsp_chan_ff, rsp_chan_in;
   logic                       rsp_last_ff, rsp_last_in;

   // ---------------- configuration port ----------------
   assign csr_bus.ready = 1'b1;
   assign raw_cols = SAT_W'(csr_bus.data);
   assign raw_rows = csr_bus.data;

   always_comb begin
      threshold_in = threshold_ff;
      cols_in      = cols_ff;
      rows_in      = rows_ff;
      restart      = 1'b0;
      if (csr_bus.valid) begin
         unique case (tbe_pkg::csr_index_type'(csr_bus.index))
            tbe_pkg::CSR_THRESHOLD: begin
               threshold_in = csr_bus.data[tbe_pkg::CHAN_W-1:0];
            end
            tbe_pkg::CSR_COLUMNS: begin
               restart = 1'b1;
               if (raw_cols < SAT_W'(tbe_pkg::SIZE_MIN)) begin
                  cols_in = CNT_W'(tbe_pkg::SIZE_MIN);
               end else if (raw_cols > SAT_W'(MAX_LINE_WIDTH)) begin
                  cols_in = CNT_W'(MAX_LINE_WIDTH);
               end else begin
                  cols_in = CNT_W'(raw_cols);
               end
            end
            tbe_pkg::CSR_ROWS: begin
               restart = 1'b1;
               if (raw_rows < tbe_pkg::SIZE_W'(tbe_pkg::SIZE_MIN)) begin
                  rows_in = tbe_pkg::SIZE_W'(tbe_pkg::SIZE_MIN);
               end else if (raw_rows > tbe_pkg::SIZE_W'(tbe_pkg::ROWS_MAX)) begin
                  rows_in = tbe_pkg::SIZE_W'(tbe_pkg::ROWS_MAX);
               end else begin
                  rows_in = raw_rows;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------- input side: position and emit decision ----------------
   assign req_fire = req_bus.valid && req_bus.ready;
   assign is_pixel = !req_bus.mode;
   assign cols_p1  = PEND_W'(cols_ff) + PEND_W'(1);

   assign col_first   = (out_col_ff == '0);
   assign col_last    = (CNT_W'(out_col_ff) == cols_ff - CNT_W'(1));
   assign row_first   = (out_row_ff == '0);
   assign row_last    = (tbe_pkg::SIZE_W'(out_row_ff) == rows_ff - tbe_pkg::SIZE_W'(1));
   assign in_col_last = (CNT_W'(in_col_ff) == cols_ff - CNT_W'(1));

   // a pixel completes a window once a row plus one results are pending
   assign emit_c   = is_pixel ? (pend_ff == cols_p1) : (pend_ff != '0);
   assign bright_c = !is_pixel || row_first || row_last || col_first || col_last;
   assign last_c   = row_last && col_last;

   always_comb begin
      in_col_in  = in_col_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      pend_in    = pend_ff;
      if (restart) begin
         in_col_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
         pend_in    = '0;
      end else if (req_fire) begin
         if (is_pixel) begin
            in_col_in = in_col_last ? '0 : in_col_ff + COL_W'(1);
            if (!emit_c) begin
               pend_in = pend_ff + PEND_W'(1);
            end
         end else if (emit_c) begin
            pend_in = pend_ff - PEND_W'(1);
         end
         if (emit_c) begin
            if (col_last) begin
               out_col_in = '0;
               out_row_in = row_last ? '0 : out_row_ff + tbe_pkg::ROW_W'(1);
            end else begin
               out_col_in = out_col_ff + COL_W'(1);
            end
         end
      end
   end

   // ---------------- compare stage ----------------
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign s1_fire       = s1_valid_ff && (!s1_ff.emit || out_free);
   assign req_bus.ready = !s1_valid_ff || s1_fire;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_in       = s1_ff;
      if (req_fire) begin
         s1_valid_in  = 1'b1;
         s1_in.pixel  = is_pixel;
         s1_in.emit   = emit_c;
         s1_in.bright = bright_c;
         s1_in.last   = last_c;
         s1_in.px     = {req_bus.blue_in, req_bus.green_in, req_bus.red_in};
         s1_in.col    = in_col_ff;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   // line stores share one ram word: upper half is the older row
   assign ram_re    = req_fire && is_pixel;
   assign ram_we    = s1_fire && s1_ff.pixel;
   assign ram_wdata = {ram_rdata[tbe_pkg::PIX_W-1:0], s1_ff.px};

   tbe_ram #(
      .WIDTH (2 * tbe_pkg::PIX_W),
      .DEPTH (MAX_LINE_WIDTH)
   ) u_line_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (s1_ff.col),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (in_col_ff),
      .rdata (ram_rdata)
   );

   always_comb begin
      win_next    = win_ff;
      win_next[0] = win_ff[1];
      win_next[1] = win_ff[2];
      win_next[2] = ram_rdata[2*tbe_pkg::PIX_W-1:tbe_pkg::PIX_W];
      win_next[3] = win_ff[4];
      win_next[4] = win_ff[5];
      win_next[5] = ram_rdata[tbe_pkg::PIX_W-1:0];
      win_next[6] = win_ff[7];
      win_next[7] = win_ff[8];
      win_next[8] = s1_ff.px;
   end

   tbe_judge u_judge (
      .window    (win_next),
      .threshold (threshold_ff),
      .dark      (dark)
   );

   // ---------------- output register ----------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_chan_in  = rsp_chan_ff;
      rsp_last_in  = rsp_last_ff;
      if (s1_fire && s1_ff.emit) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = s1_ff.last;
         for (int k = 0; k < tbe_pkg::NUM_CHAN; k++) begin
            rsp_chan_in[k] = (s1_ff.bright || !dark[k]) ? tbe_pkg::BRIGHT : tbe_pkg::DARK;
         end
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.red_out   = rsp_chan_ff[0];
   assign rsp_bus.green_out = rsp_chan_ff[1];
   assign rsp_bus.blue_out  = rsp_chan_ff[2];
   assign rsp_bus.frame_end = rsp_last_ff;

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= tbe_pkg::THRESH_RESET;
         cols_ff      <= CNT_W'(COLS_RESET);
         rows_ff      <= tbe_pkg::SIZE_W'(tbe_pkg::ROWS_MAX);
         in_col_ff    <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         pend_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         win_ff       <= '0;
      end else begin
         threshold_ff <= threshold_in;
         cols_ff      <= cols_in;
         rows_ff      <= rows_in;
         in_col_ff    <= in_col_in;
         out_col_ff   <= out_col_in;
         out_row_ff   <= out_row_in;
         pend_ff      <= pend_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (ram_we) begin
            win_ff <= win_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_ff       <= s1_in;
      rsp_chan_ff <= rsp_chan_in;
      rsp_last_ff <= rsp_last_in;
   end

   // ---------------- assertions ----------------
   `TBE_ASSERT_IMPL(a_pend_bound, 1'b1, pend_ff <= cols_p1,
      "pending count above one row plus one")
   `TBE_ASSERT_IMPL(a_ram_no_clash, ram_we && ram_re, s1_ff.col != in_col_ff,
      "line store read and write hit the same column")
   `TBE_ASSERT_NEXT(a_bright_result, s1_fire && s1_ff.emit && s1_ff.bright,
      rsp_bus.red_out == tbe_pkg::BRIGHT && rsp_bus.green_out == tbe_pkg::BRIGHT &&
      rsp_bus.blue_out == tbe_pkg::BRIGHT,
      "border or flush result is not bright")
   `TBE_ASSERT_NEXT(a_frame_wrap, req_fire && emit_c && last_c && !restart,
      out_row_ff == '0 && out_col_ff == '0,
      "output position did not wrap after the last pixel")

endmodule

`default_nettype wire
